>>> sv/sfa_pkg.sv
// Shared types, widths and constant tables for the spring force accumulator.
// No dependencies; every other file imports this package.
package sfa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int REST_W     = 32;
    localparam int STIFF_W    = 32;
    localparam int EXPO_W     = 16;
    localparam int SUM_W      = 48;
    localparam int VAL_W      = SUM_W - 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    localparam logic [VAL_W-1:0]  VAL_CAP     = '1;
    localparam logic [STIFF_W-1:0] STIFF_RESET = 32'h0001_0000;
    localparam logic [EXPO_W-1:0]  EXPO_RESET  = 16'h0200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS = 8'd0,
        REG_EXPONENT  = 8'd1
    } cfg_reg_t;

    // one spring request as the back end sees it
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] dmag;
        logic [2:0]             dneg;
        logic [REST_W-1:0]      rest;
        logic                   present;
        logic                   node_end;
        logic                   last_node;
    } cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] force_x;
        logic signed [SUM_W-1:0] force_y;
        logic signed [SUM_W-1:0] force_z;
        logic                    degenerate_seen;
        logic                    saturated;
        logic                    end_of_mesh;
    } res_t;

    // factors 2^(2^-k), k = 1..16, in Q1.30, each a floor root of the one before
    typedef logic [15:0][30:0] root_tbl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] c;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (c * c <= v)
                res = c;
        end
        return res;
    endfunction

    function automatic root_tbl_t build_roots();
        root_tbl_t   tbl;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            r = isqrt64(r << 30);
            tbl[k] = r[30:0];
        end
        return tbl;
    endfunction

    localparam root_tbl_t EXP_ROOTS = build_roots();

endpackage

>>> sv/sfa_front.sv
// Front end: accepts spring requests, forms the difference vector and classifies them.
// Depends on sfa_pkg.
module sfa_front (
    input  logic                              push,
    input  logic                              q_full,
    input  logic signed [sfa_pkg::POS_W-1:0]  node_x,
    input  logic signed [sfa_pkg::POS_W-1:0]  node_y,
    input  logic signed [sfa_pkg::POS_W-1:0]  node_z,
    input  logic signed [sfa_pkg::POS_W-1:0]  neighbor_x,
    input  logic signed [sfa_pkg::POS_W-1:0]  neighbor_y,
    input  logic signed [sfa_pkg::POS_W-1:0]  neighbor_z,
    input  logic [sfa_pkg::REST_W-1:0]        rest_length,
    input  logic                              spring_present,
    input  logic                              last_spring,
    input  logic                              last_node,
    output logic                              q_push,
    output sfa_pkg::cmd_t                     cmd
);
    import sfa_pkg::*;

    logic [2:0][DIFF_W-1:0] diff;

    assign diff[0] = DIFF_W'({node_x[POS_W-1], node_x} - {neighbor_x[POS_W-1], neighbor_x});
    assign diff[1] = DIFF_W'({node_y[POS_W-1], node_y} - {neighbor_y[POS_W-1], neighbor_y});
    assign diff[2] = DIFF_W'({node_z[POS_W-1], node_z} - {neighbor_z[POS_W-1], neighbor_z});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cmd.dneg[i] = diff[i][DIFF_W-1];
            cmd.dmag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : diff[i];
        end
        cmd.rest      = rest_length;
        cmd.present   = spring_present;
        // a request without a spring closes the node regardless of last_spring
        cmd.node_end  = last_spring | ~spring_present;
        cmd.last_node = last_node;
    end

    assign q_push = push & ~q_full;

endmodule

>>> sv/sfa_cmd_queue.sv
// Short request queue between the front end and the back end.
// Depends on sfa_pkg.
module sfa_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfa_pkg::cmd_t wr_data,
    output logic          q_full,
    output logic          rd_valid,
    input  logic          rd_en,
    output sfa_pkg::cmd_t rd_data
);
    import sfa_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign q_full   = (count_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en & ~q_full;
    assign do_rd    = rd_en & rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> sv/sfa_back.sv
// Back end: sequential spring engine (sqrt, divides, log2, exp2, multiplies) and node sums.
// Depends on sfa_pkg; fed by sfa_cmd_queue.
module sfa_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  sfa_pkg::cmd_t                      cmd,
    output logic                               cmd_take,
    input  logic [sfa_pkg::STIFF_W-1:0]        stiffness,
    input  logic signed [sfa_pkg::EXPO_W-1:0]  exponent,
    output logic                               res_valid,
    output sfa_pkg::res_t                      res,
    input  logic                               res_pop
);
    import sfa_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SQUARE = 15'b000000000000010,
        S_SQRT   = 15'b000000000000100,
        S_DIV    = 15'b000000000001000,
        S_NORM   = 15'b000000000010000,
        S_LOG    = 15'b000000000100000,
        S_EMUL   = 15'b000000001000000,
        S_EXPI   = 15'b000000010000000,
        S_EXP    = 15'b000000100000000,
        S_EXPF   = 15'b000001000000000,
        S_DIFF   = 15'b000010000000000,
        S_FMUL   = 15'b000100000000000,
        S_RATIO  = 15'b001000000000000,
        S_CMUL   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    // control
    state_t                  state_reg, state_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic                    zflag_reg, zflag_next;
    logic                    oflag_reg, oflag_next;

    // datapath
    cmd_t               item_reg, item_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic               pass_reg, pass_next;
    logic [65:0]        rad_reg, rad_next;
    logic [36:0]        rem_reg, rem_next;
    logic [32:0]        root_reg, root_next;
    logic [48:0]        dvd_reg, dvd_next;
    logic [5:0]         msb_reg, msb_next;
    logic [30:0]        m_reg, m_next;
    logic [15:0]        frac_reg, frac_next;
    logic signed [38:0] e24_reg, e24_next;
    logic [14:0]        ip_reg, ip_next;
    logic [VAL_W-1:0]   p1_reg, p1_next;
    logic [VAL_W-1:0]   p2_reg, p2_next;
    logic               fneg_reg, fneg_next;
    logic [VAL_W-1:0]   fmag_reg, fmag_next;
    logic [30:0]        q_reg, q_next;
    logic [78:0]        acc_reg, acc_next;
    logic [54:0]        pp_reg, pp_next;
    res_t               res_reg, res_next;

    // shared arithmetic
    logic [DIFF_W-1:0]  sq_op;
    logic [65:0]        sq_prod;
    logic [36:0]        sqrt_t, sqrt_trial;
    logic [32:0]        div_t;
    logic [REST_W-1:0]  rest_eff;
    logic [30:0]        m31_b;
    logic [61:0]        m31_prod;
    logic [31:0]        m31_top;
    logic signed [22:0] lg;
    logic [39:0]        e24_neg;
    logic [30:0]        e_sel;
    logic [15:0]        exp_sh, exp_nsh;
    logic [63:0]        exp_wide;
    logic [VAL_W-1:0]   exp_val;
    logic               exp_sat;
    logic [31:0]        mb;
    logic [55:0]        mul_lo;
    logic [54:0]        mul_hi;
    logic [48:0]        q_div;
    logic [34:0]        ratio_r;
    logic [48:0]        add_cur, add_val, add_res;

    assign sq_op    = item_reg.dmag[cnt_reg[1:0]];
    assign sq_prod  = sq_op * sq_op;
    assign rest_eff = (item_reg.rest == '0) ? REST_W'(1) : item_reg.rest;

    assign sqrt_t     = {rem_reg[34:0], rad_reg[65:64]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};
    assign div_t      = {rem_reg[31:0], dvd_reg[48]};
    assign q_div      = {dvd_reg[47:0], (div_t >= {1'b0, rest_eff})};
    assign ratio_r    = rem_reg[34:0];

    // one 31x31 multiplier shared by the log squaring and the exp product
    assign m31_b    = (state_reg == S_LOG) ? m_reg : EXP_ROOTS[cnt_reg[3:0]];
    assign m31_prod = m_reg * m31_b;
    assign m31_top  = m31_prod[61:30];

    assign lg      = {($signed({1'b0, msb_reg}) - 7'sd16), frac_reg};
    assign e24_neg = 40'(-{e24_reg[38], e24_reg});
    assign e_sel   = pass_reg ? e24_neg[39:9] : e24_reg[38:8];

    // exp2 result shift toward Q16.16
    always_comb
    begin
        exp_sh   = 16'($signed({ip_reg[14], ip_reg}) - 16'sd14);
        exp_nsh  = 16'(-exp_sh);
        exp_wide = {33'd0, m_reg} << exp_sh[5:0];
        exp_sat  = 1'b0;
        exp_val  = '0;
        if (!exp_sh[15])
        begin
            if (exp_sh > 16'd32 || exp_wide[63:VAL_W] != '0)
            begin
                exp_sat = 1'b1;
                exp_val = VAL_CAP;
            end
            else
                exp_val = exp_wide[VAL_W-1:0];
        end
        else if (exp_nsh < 16'd31)
            exp_val = VAL_W'(m_reg >> exp_nsh[4:0]);
    end

    // 24-bit and 23-bit slices of a 47-bit operand against a 32-bit one
    assign mb     = (state_reg == S_FMUL) ? stiffness : {1'b0, q_reg};
    assign mul_lo = fmag_reg[23:0] * mb;
    assign mul_hi = fmag_reg[46:24] * mb;

    assign add_cur = {sum_reg[comp_reg][SUM_W-1], sum_reg[comp_reg]};
    assign add_val = {2'b00, acc_reg[76:30]};
    assign add_res = (fneg_reg ^ item_reg.dneg[comp_reg]) ? add_cur - add_val
                                                          : add_cur + add_val;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        sum_next       = sum_reg;
        zflag_next     = zflag_reg;
        oflag_next     = oflag_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        pass_next      = pass_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        dvd_next       = dvd_reg;
        msb_next       = msb_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        e24_next       = e24_reg;
        ip_next        = ip_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        fneg_next      = fneg_reg;
        fmag_next      = fmag_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        pp_next        = pp_reg;
        res_next       = res_reg;
        cmd_take       = 1'b0;

        if (res_pop)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take  = 1'b1;
                    item_next = cmd;
                    cnt_next  = '0;
                    rad_next  = '0;
                    state_next = cmd.present ? S_SQUARE : S_DONE;
                end
            end
            S_SQUARE:
            begin
                rad_next = rad_reg + sq_prod;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd2)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_t >= sqrt_trial)
                begin
                    rem_next  = sqrt_t - sqrt_trial;
                    root_next = {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next  = sqrt_t;
                    root_next = {root_reg[31:0], 1'b0};
                end
                rad_next = {rad_reg[63:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd32)
                begin
                    cnt_next   = '0;
                    dvd_next   = {root_next, 16'd0};
                    rem_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (root_reg == '0)
                begin
                    // zero-length spring: skipped, only flagged
                    zflag_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next = (div_t >= {1'b0, rest_eff}) ? 37'(div_t - {1'b0, rest_eff})
                                                           : 37'(div_t);
                    dvd_next = q_div;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd48)
                    begin
                        if (q_div == '0)
                            dvd_next = 49'd1;
                        msb_next   = 6'd48;
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                if (dvd_reg[48])
                begin
                    m_next     = dvd_reg[48:18];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    dvd_next = {dvd_reg[47:0], 1'b0};
                    msb_next = msb_reg - 1'b1;
                end
            end
            S_LOG:
            begin
                if (m31_top[31])
                begin
                    m_next    = m31_top[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = m31_top[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd15)
                    state_next = S_EMUL;
            end
            S_EMUL:
            begin
                e24_next   = exponent * lg;
                pass_next  = 1'b0;
                state_next = S_EXPI;
            end
            S_EXPI:
            begin
                m_next     = 31'd1 << 30;
                frac_next  = e_sel[15:0];
                ip_next    = e_sel[30:16];
                cnt_next   = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                if (frac_reg[4'd15 - cnt_reg[3:0]])
                    m_next = m31_top[30:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd15)
                    state_next = S_EXPF;
            end
            S_EXPF:
            begin
                if (exp_sat)
                    oflag_next = 1'b1;
                if (!pass_reg)
                begin
                    p1_next    = exp_val;
                    pass_next  = 1'b1;
                    state_next = S_EXPI;
                end
                else
                begin
                    p2_next    = exp_val;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                fneg_next  = (p1_reg > p2_reg);
                fmag_next  = (p1_reg > p2_reg) ? p1_reg - p2_reg : p2_reg - p1_reg;
                cnt_next   = '0;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    acc_next = 79'(mul_lo);
                    2'd1:    pp_next  = mul_hi;
                    2'd2:    acc_next = acc_reg + {pp_reg, 24'd0};
                    default:
                    begin
                        if (acc_reg[78:63] != '0)
                        begin
                            fmag_next  = VAL_CAP;
                            oflag_next = 1'b1;
                        end
                        else
                            fmag_next = acc_reg[62:16];
                        comp_next  = '0;
                        cnt_next   = '0;
                        rem_next   = 37'(item_reg.dmag[0]);
                        q_next     = '0;
                        state_next = S_RATIO;
                    end
                endcase
            end
            S_RATIO:
            begin
                // unit vector component |D|/L in Q1.30
                if (ratio_r >= {2'b00, root_reg})
                begin
                    rem_next = {1'b0, 35'(ratio_r - {2'b00, root_reg}), 1'b0};
                    q_next   = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = {1'b0, ratio_r, 1'b0};
                    q_next   = {q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd30)
                begin
                    cnt_next   = '0;
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    acc_next = 79'(mul_lo);
                    2'd1:    pp_next  = mul_hi;
                    2'd2:    acc_next = acc_reg + {pp_reg, 24'd0};
                    default:
                    begin
                        if (!add_res[48] && add_res[47])
                        begin
                            sum_next[comp_reg] = {1'b0, VAL_CAP};
                            oflag_next = 1'b1;
                        end
                        else if (add_res[48] && !add_res[47])
                        begin
                            sum_next[comp_reg] = {1'b1, {VAL_W{1'b0}}};
                            oflag_next = 1'b1;
                        end
                        else
                            sum_next[comp_reg] = add_res[SUM_W-1:0];
                        cnt_next = '0;
                        q_next   = '0;
                        if (comp_reg == 2'd2)
                            state_next = S_DONE;
                        else
                        begin
                            comp_next  = comp_reg + 1'b1;
                            rem_next   = 37'(item_reg.dmag[comp_reg + 1'b1]);
                            state_next = S_RATIO;
                        end
                    end
                endcase
            end
            S_DONE:
            begin
                if (!item_reg.node_end)
                    state_next = S_IDLE;
                else if (!res_valid_reg)
                begin
                    res_next.force_x         = sum_reg[0];
                    res_next.force_y         = sum_reg[1];
                    res_next.force_z         = sum_reg[2];
                    res_next.degenerate_seen = zflag_reg;
                    res_next.saturated       = oflag_reg;
                    res_next.end_of_mesh     = item_reg.last_node;
                    res_valid_next           = 1'b1;
                    for (int i = 0; i < 3; i++)
                        sum_next[i] = '0;
                    zflag_next = 1'b0;
                    oflag_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
            zflag_reg     <= 1'b0;
            oflag_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            sum_reg       <= sum_next;
            zflag_reg     <= zflag_next;
            oflag_reg     <= oflag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        pass_reg <= pass_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvd_reg  <= dvd_next;
        msb_reg  <= msb_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        e24_reg  <= e24_next;
        ip_reg   <= ip_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        fneg_reg <= fneg_next;
        fmag_reg <= fmag_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        pp_reg   <= pp_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sv/spring_force_accumulator_core.sv
// A spring request passes from the queue hand-off through square, sqrt, stretch divide, normalize, log,
// two exp passes and a stiffness multiply, then three unit divides each followed by a multiply.
// A request without a spring goes straight to the node close; a node end waits while an earlier
// result is still unpopped. The single iterative back end takes a new spring only once it is done
// with the last one; the 2-entry queue accepts requests meanwhile.
// Reset (async, active low) clears sums, flags, queue and result; stiffness = 1.0, exponent = 2.0.
module spring_force_accumulator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [sfa_pkg::POS_W-1:0]   node_x,
    input  logic signed [sfa_pkg::POS_W-1:0]   node_y,
    input  logic signed [sfa_pkg::POS_W-1:0]   node_z,
    input  logic signed [sfa_pkg::POS_W-1:0]   neighbor_x,
    input  logic signed [sfa_pkg::POS_W-1:0]   neighbor_y,
    input  logic signed [sfa_pkg::POS_W-1:0]   neighbor_z,
    input  logic [sfa_pkg::REST_W-1:0]         rest_length,
    input  logic                               spring_present,
    input  logic                               last_spring,
    input  logic                               last_node,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [sfa_pkg::SUM_W-1:0]   force_x,
    output logic signed [sfa_pkg::SUM_W-1:0]   force_y,
    output logic signed [sfa_pkg::SUM_W-1:0]   force_z,
    output logic                               degenerate_seen,
    output logic                               saturated,
    output logic                               end_of_mesh,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sfa_pkg::*;

    logic [STIFF_W-1:0] stiff_reg;
    logic [EXPO_W-1:0]  expo_reg;
    logic               q_full, q_push, q_valid, q_take;
    cmd_t               front_cmd, q_cmd;
    logic               res_valid;
    res_t               res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
            expo_reg  <= EXPO_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_STIFFNESS)
                stiff_reg <= cfg_data[STIFF_W-1:0];
            else if (cfg_index == REG_EXPONENT)
                expo_reg <= cfg_data[EXPO_W-1:0];
        end
    end

    sfa_front u_front (
        .push           (push),
        .q_full         (q_full),
        .node_x         (node_x),
        .node_y         (node_y),
        .node_z         (node_z),
        .neighbor_x     (neighbor_x),
        .neighbor_y     (neighbor_y),
        .neighbor_z     (neighbor_z),
        .rest_length    (rest_length),
        .spring_present (spring_present),
        .last_spring    (last_spring),
        .last_node      (last_node),
        .q_push         (q_push),
        .cmd            (front_cmd)
    );

    sfa_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (front_cmd),
        .q_full   (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_data  (q_cmd)
    );

    sfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (q_take),
        .stiffness (stiff_reg),
        .exponent  ($signed(expo_reg)),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop & res_valid)
    );

    assign full            = q_full;
    assign empty           = ~res_valid;
    assign force_x         = res.force_x;
    assign force_y         = res.force_y;
    assign force_z         = res.force_z;
    assign degenerate_seen = res.degenerate_seen;
    assign saturated       = res.saturated;
    assign end_of_mesh     = res.end_of_mesh;

endmodule

>>> sv/sfa_checker.sv
// Port-level checks for spring_force_accumulator_core, attached by bind.
// Depends on sfa_pkg for the result width.
module sfa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic                             cfg_ready,
    input logic signed [sfa_pkg::SUM_W-1:0] force_x,
    input logic                             saturated,
    input logic                             end_of_mesh
);
    import sfa_pkg::*;

    // reset leaves no result and room for requests
    a_reset_state: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("result or full flag present during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config channel not ready");

    // the queue only fills from a request
    a_full_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue became full without a request");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("pending result dropped");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(force_x) && $stable(saturated) && $stable(end_of_mesh)))
        else $error("pending result changed");

endmodule

bind spring_force_accumulator_core sfa_checker u_sfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .cfg_ready   (cfg_ready),
    .force_x     (force_x),
    .saturated   (saturated),
    .end_of_mesh (end_of_mesh)
);

>>> verif/tb_spring_force_accumulator_core.sv
// Self-checking testbench for spring_force_accumulator_core.
// Depends on sfa_pkg and the core RTL; a bit-exact force predictor checks every node result.
`timescale 1ns / 100ps

module tb_spring_force_accumulator_core;
    import sfa_pkg::*;

    localparam int              SPRING_LAT   = 320;   // worst back-end time per spring, rounded up
    localparam int              STALL_LIMIT  = 5000;
    localparam int              RANDOM_ITEMS = 1280;
    localparam int              PHASES       = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;  // unmapped index, write is dropped
    localparam longint          SUM_MAX      = 64'sd140737488355327;
    localparam longint          SUM_MIN      = -64'sd140737488355328;
    localparam logic [63:0]     STRETCH_MAX  = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [POS_W-1:0] nx, ny, nz, bx, by, bz;
        logic [REST_W-1:0]       rest;
        bit                      present, last_s, last_n;
    } spring_req_t;

    function automatic logic [127:0] root128(input logic [127:0] v);
        logic [127:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    class force_scoreboard;
        res_t        pending_q[$];
        int          errors;
        longint      sx, sy, sz;
        bit          zflag, oflag, sat_hit;
        logic [31:0] stiff;
        logic [15:0] expo;
        logic [63:0] roots[16];

        function new();
            logic [127:0] r;
            r = 128'd1 << 31;
            for (int k = 0; k < 16; k++) begin
                r = root128(r << 30);
                roots[k] = r[63:0];
            end
            stiff = STIFF_RESET;
            expo  = EXPO_RESET;
            errors = 0;
            clear_node();
        endfunction

        function void clear_node();
            sx = 0; sy = 0; sz = 0;
            zflag = 0; oflag = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
            if (idx == REG_STIFFNESS)
                stiff = data;
            else if (idx == REG_EXPONENT)
                expo = data[15:0];
        endfunction

        // Q.16 log2, fraction by repeated squaring of a Q1.30 mantissa
        function longint log2q(input logic [63:0] x);
            int          msb;
            logic [63:0] m, frac;
            msb = 0;
            frac = 0;
            while ((x >> msb) > 1)
                msb++;
            m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return longint'(msb - FRAC_BITS) * 65536 + longint'(frac);
        endfunction

        function logic [63:0] pow2q(input longint e);
            longint      ip, shift;
            logic [63:0] fp, m, v;
            ip = e >>> 16;
            fp = e & 64'hFFFF;
            m = 64'd1 << 30;
            for (int k = 1; k <= 16; k++)
                if (fp[16-k])
                    m = (m * roots[k-1]) >> 30;
            shift = ip + FRAC_BITS - 30;
            if (shift >= 0) begin
                if (shift > 32) begin
                    sat_hit = 1;
                    return 64'(VAL_CAP);
                end
                v = m << shift;
                if (v > VAL_CAP) begin
                    sat_hit = 1;
                    return 64'(VAL_CAP);
                end
                return v;
            end
            if (-shift >= 64)
                return 0;
            return m >> (-shift);
        endfunction

        function longint add_sat(input longint s, input logic [63:0] mag, input bit neg);
            longint v;
            v = neg ? s - longint'(mag) : s + longint'(mag);
            if (v > SUM_MAX) begin
                v = SUM_MAX;
                oflag = 1;
            end
            if (v < SUM_MIN) begin
                v = SUM_MIN;
                oflag = 1;
            end
            return v;
        endfunction

        function void add_spring(input longint d[3], input logic [31:0] rest_in);
            logic [63:0]  mag[3];
            logic [127:0] acc, wide, root_full;
            logic [63:0]  len, rest, stretch, p1, p2, fmag, c;
            longint       lg, e24, diff;
            bit           fneg;
            acc = '0;
            sat_hit = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = d[i] < 0 ? -d[i] : d[i];
                acc += {64'd0, mag[i]} * {64'd0, mag[i]};
            end
            root_full = root128(acc);
            len = root_full[63:0];
            if (len == 0) begin
                zflag = 1;
                return;
            end
            rest = (rest_in == 0) ? 64'd1 : {32'd0, rest_in};
            if (len / rest > (STRETCH_MAX >> FRAC_BITS)) begin
                stretch = STRETCH_MAX;
                sat_hit = 1;
            end else begin
                wide = ({64'd0, len} << FRAC_BITS) / rest;
                if (wide > STRETCH_MAX) begin
                    stretch = STRETCH_MAX;
                    sat_hit = 1;
                end else
                    stretch = wide[63:0];
            end
            if (stretch == 0)
                stretch = 1;
            lg  = log2q(stretch);
            e24 = longint'($signed(expo)) * lg;
            p1  = pow2q(e24 >>> 8);
            p2  = pow2q((-e24) >>> 9);
            diff = longint'(p1) - longint'(p2);
            fneg = diff > 0;
            wide = {64'd0, (diff < 0) ? -diff : diff} * {96'd0, stiff};
            wide = wide >> FRAC_BITS;
            if (wide > VAL_CAP) begin
                fmag = 64'(VAL_CAP);
                sat_hit = 1;
            end else
                fmag = wide[63:0];
            if (sat_hit)
                oflag = 1;
            for (int i = 0; i < 3; i++) begin
                wide = ({64'd0, mag[i]} << 30) / len;
                wide = ({64'd0, fmag} * wide) >> 30;
                c = wide[63:0];
                if (i == 0)
                    sx = add_sat(sx, c, fneg != (d[i] < 0));
                else if (i == 1)
                    sy = add_sat(sy, c, fneg != (d[i] < 0));
                else
                    sz = add_sat(sz, c, fneg != (d[i] < 0));
            end
        endfunction

        function void note_request(input spring_req_t r);
            longint d[3];
            res_t   e;
            if (r.present) begin
                d[0] = longint'(r.nx) - longint'(r.bx);
                d[1] = longint'(r.ny) - longint'(r.by);
                d[2] = longint'(r.nz) - longint'(r.bz);
                add_spring(d, r.rest);
            end
            if (r.present && !r.last_s)
                return;
            e.force_x = sx[SUM_W-1:0];
            e.force_y = sy[SUM_W-1:0];
            e.force_z = sz[SUM_W-1:0];
            e.degenerate_seen = zflag;
            e.saturated = oflag;
            e.end_of_mesh = r.last_n;
            pending_q.push_back(e);
            clear_node();
        endfunction

        function void check(input res_t got);
            res_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected node result %p", $time, got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.force_x !== e.force_x) begin
                $display("%0t: force_x exp %0d got %0d", $time, e.force_x, got.force_x);
                errors++;
            end
            if (got.force_y !== e.force_y) begin
                $display("%0t: force_y exp %0d got %0d", $time, e.force_y, got.force_y);
                errors++;
            end
            if (got.force_z !== e.force_z) begin
                $display("%0t: force_z exp %0d got %0d", $time, e.force_z, got.force_z);
                errors++;
            end
            if (got.degenerate_seen !== e.degenerate_seen) begin
                $display("%0t: degenerate_seen exp %0b got %0b", $time,
                         e.degenerate_seen, got.degenerate_seen);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $display("%0t: saturated exp %0b got %0b", $time, e.saturated, got.saturated);
                errors++;
            end
            if (got.end_of_mesh !== e.end_of_mesh) begin
                $display("%0t: end_of_mesh exp %0b got %0b", $time,
                         e.end_of_mesh, got.end_of_mesh);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, push, full, empty, pop, cfg_valid, cfg_ready;
    logic signed [POS_W-1:0] node_x, node_y, node_z, neighbor_x, neighbor_y, neighbor_z;
    logic [REST_W-1:0]       rest_length;
    logic                    spring_present, last_spring, last_node;
    logic signed [SUM_W-1:0] force_x, force_y, force_z;
    logic                    degenerate_seen, saturated, end_of_mesh;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    force_scoreboard sb;
    bit              quiet;
    int              idle_cycles;

    spring_force_accumulator_core uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        push = 0; pop = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        node_x = '0; node_y = '0; node_z = '0;
        neighbor_x = '0; neighbor_y = '0; neighbor_z = '0;
        rest_length = 32'h0001_0000;
        spring_present = 0; last_spring = 0; last_node = 0;
        quiet = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    // result side: random pop stalls, none in the quiet tail
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            pop <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check('{force_x, force_y, force_z, degenerate_seen, saturated, end_of_mesh});
            if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_spring_force_accumulator_core failed");
                $finish;
            end
        end
    end

    task automatic send_spring(input spring_req_t r);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        node_x <= r.nx; node_y <= r.ny; node_z <= r.nz;
        neighbor_x <= r.bx; neighbor_y <= r.by; neighbor_z <= r.bz;
        rest_length <= r.rest;
        spring_present <= r.present; last_spring <= r.last_s; last_node <= r.last_n;
        push <= 1;
        do @(posedge clk); while (full);
        sb.note_request(r);
    endtask

    // drains every expected result, then lets an unfinished spring settle
    task automatic drain();
        push <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SPRING_LAT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic spring_req_t make_spring(input int kind, input bit present,
                                                input bit last_s, input bit last_n);
        spring_req_t r;
        logic [31:0] base;
        r.present = present; r.last_s = last_s; r.last_n = last_n;
        r.nx = $urandom; r.ny = $urandom; r.nz = $urandom;
        r.rest = $urandom;
        case (kind)
            0: begin  // coincident ends
                r.bx = r.nx; r.by = r.ny; r.bz = r.nz;
            end
            1: begin  // full-range coordinates
                r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
                if (r.rest == 0) r.rest = 1;
            end
            2: begin  // one-LSB spring against a long rest length
                r.bx = r.nx; r.by = r.ny; r.bz = r.nz - 1;
                r.rest = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            end
            default: begin  // moderate lengths around the rest length
                base = $urandom_range(1 << 18, 1 << 19);
                r.bx = r.nx + $signed($urandom_range(0, 2 * base)) - $signed(base);
                r.by = r.ny + $signed($urandom_range(0, 2 * base)) - $signed(base);
                r.bz = r.nz + $signed($urandom_range(0, 2 * base)) - $signed(base);
                r.rest = $urandom_range(1 << 12, 1 << 20);
            end
        endcase
        return r;
    endfunction

    initial
    begin
        spring_req_t r;
        int          n_springs, kind, per_phase;
        logic [31:0] stiff_set[PHASES];
        logic [15:0] expo_set[PHASES];
        @(posedge rst_n);
        @(posedge clk);

        // directed: extremes, degenerate springs, empty nodes
        r = make_spring(0, 1, 1, 0);
        send_spring(r);
        r = make_spring(0, 1, 0, 0);
        send_spring(r);
        r = make_spring(3, 1, 1, 1);
        send_spring(r);
        r = make_spring(1, 1, 0, 0);
        r.nx = 32'h7FFF_FFFF; r.ny = 32'h7FFF_FFFF; r.nz = 32'h7FFF_FFFF;
        r.bx = 32'h8000_0000; r.by = 32'h8000_0000; r.bz = 32'h8000_0000;
        r.rest = 32'd1;
        send_spring(r);
        r.nx = 32'h8000_0000; r.ny = 32'h8000_0000; r.nz = 32'h8000_0000;
        r.bx = 32'h7FFF_FFFF; r.by = 32'h7FFF_FFFF; r.bz = 32'h7FFF_FFFF;
        r.rest = 32'hFFFF_FFFF; r.last_s = 1;
        send_spring(r);
        r = make_spring(2, 1, 1, 0);
        send_spring(r);
        r = make_spring(3, 0, 0, 1);
        send_spring(r);
        r = make_spring(3, 0, 1, 0);
        send_spring(r);
        r = make_spring(3, 1, 0, 0);
        r.bx = r.nx + 32'sh0001_0000; r.by = r.ny; r.bz = r.nz; r.rest = 32'h0001_0000;
        send_spring(r);
        r = make_spring(3, 1, 1, 1);
        r.bx = r.nx; r.by = r.ny - 32'sh0002_0000; r.bz = r.nz; r.rest = 32'h0001_0000;
        send_spring(r);

        stiff_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000,
                      $urandom, 32'h0002_8000};
        expo_set  = '{16'h0200, 16'h7FFF, 16'h8000, 16'h0000, 16'($urandom), 16'hFF00};
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_reg(REG_STIFFNESS, stiff_set[ph]);
            write_reg(REG_EXPONENT, {16'hA5A5, expo_set[ph]});
            if (ph == 2)
                write_reg(REG_SPARE, $urandom);
            if (ph == PHASES - 1)
                quiet = 1;
            for (int i = 0; i < per_phase; ) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = make_spring(3, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    send_spring(r);
                    i++;
                end else begin
                    n_springs = $urandom_range(1, 4);
                    for (int s = 0; s < n_springs; s++) begin
                        case ($urandom_range(0, 19))
                            0:       kind = 0;
                            1, 2, 3: kind = 1;
                            4:       kind = 2;
                            default: kind = 3;
                        endcase
                        r = make_spring(kind, 1, s == n_springs - 1,
                                        (s == n_springs - 1) ? ($urandom_range(0, 7) == 0)
                                                             : 1'($urandom_range(0, 1)));
                        send_spring(r);
                        i++;
                    end
                end
            end
        end

        push <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SPRING_LAT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_spring_force_accumulator_core passed");
        else
            $display("tb_spring_force_accumulator_core failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/sfa_pkg.sv
sv/sfa_front.sv
sv/sfa_cmd_queue.sv
sv/sfa_back.sv
sv/spring_force_accumulator_core.sv
sv/sfa_checker.sv
verif/tb_spring_force_accumulator_core.sv
